[rtl/sbct_pkg.sv]
// sbct_pkg: widths, constants and types shared by the segment/box clip trace block
// no dependencies
package sbct_pkg;

  localparam int COORD_BITS    = 16;
  localparam int FRACTION_BITS = 16;
  localparam int PACK_W        = 48;
  localparam int NFACE         = 6;
  localparam int FW            = FRACTION_BITS + 1;
  localparam int DW            = COORD_BITS + 5;
  localparam int NW            = DW + 1;
  localparam int CNT_W         = $clog2(FRACTION_BITS + 1);
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  localparam logic [FW-1:0] FRAC_ONE  = FW'(1) << FRACTION_BITS;
  localparam logic [2:0]    FACE_NONE = 3'd6;
  localparam logic [2:0]    FACE_LAST = 3'(NFACE - 1);
  localparam logic [8:0]    GROUP_NONE = 9'h1ff;

  // one face of one box after classification
  typedef struct packed {
    logic                 active;
    logic                 is_enter;
    logic signed [NW-1:0] num;
    logic [DW-1:0]        den;
    logic signed [15:0]   plane;
  } face_t;

  typedef struct packed {
    face_t [NFACE-1:0] faces;
    logic              reject;
    logic              startout;
    logic              getout;
    logic              first;
    logic              last;
    logic [7:0]        group;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FACE = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } back_state_e;

endpackage

[rtl/sbct_ifs.sv]
// sbct_in_if / sbct_out_if: valid/ready channels of the clip trace block
// depends on nothing
interface sbct_in_if;
  logic        valid;
  logic        ready;
  logic [47:0] start_point;
  logic [47:0] end_point;
  logic [47:0] box_min;
  logic [47:0] box_max;
  logic [7:0]  hit_group;
  logic        first_box;
  logic        last_box;

  modport source (output valid, start_point, end_point, box_min, box_max, hit_group,
                  first_box, last_box, input ready);
  modport sink   (input valid, start_point, end_point, box_min, box_max, hit_group,
                  first_box, last_box, output ready);
endinterface

interface sbct_out_if;
  logic               valid;
  logic               ready;
  logic               box_was_hit;
  logic [16:0]        trace_fraction;
  logic [2:0]         best_face;
  logic signed [15:0] best_plane_dist;
  logic signed [8:0]  best_group;
  logic               any_hit;
  logic               trace_done;

  modport source (output valid, box_was_hit, trace_fraction, best_face, best_plane_dist,
                  best_group, any_hit, trace_done, input ready);
  modport sink   (input valid, box_was_hit, trace_fraction, best_face, best_plane_dist,
                  best_group, any_hit, trace_done, output ready);
endinterface

[rtl/sbct_front.sv]
// sbct_front: per-face slab distances, reject test and divider operands for one box
// depends on sbct_pkg
module sbct_front
  import sbct_pkg::*;
(
  input  logic [PACK_W-1:0] start_point_i,
  input  logic [PACK_W-1:0] end_point_i,
  input  logic [PACK_W-1:0] box_min_i,
  input  logic [PACK_W-1:0] box_max_i,
  input  logic [7:0]        hit_group_i,
  input  logic              first_box_i,
  input  logic              last_box_i,
  input  logic [7:0]        eps_i,
  output entry_t            entry_o
);

  function automatic logic signed [COORD_BITS:0] coord_of(logic [PACK_W-1:0] p, int axis);
    logic [3*COORD_BITS+PACK_W-1:0] ext;
    logic [COORD_BITS-1:0]          v;
    ext = {{(3*COORD_BITS){1'b0}}, p};
    v   = ext[axis*COORD_BITS +: COORD_BITS];
    return {v[COORD_BITS-1], v};
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [COORD_BITS:0] v);
    logic signed [31:0] w;
    w = 32'(v);
    if (w > 32'sd32767) return 16'sh7fff;
    if (w < -32'sd32768) return 16'sh8000;
    return w[15:0];
  endfunction

  always_comb begin
    logic signed [COORD_BITS:0]   s, e, pdist;
    logic signed [COORD_BITS+1:0] diff1, diff2;
    logic signed [DW-1:0]         d1, d2, epsx;
    logic signed [NW-1:0]         d1x, epsn;
    logic                         d1pos, d2pos;
    entry_o.reject   = 1'b0;
    entry_o.startout = 1'b0;
    entry_o.getout   = 1'b0;
    entry_o.first    = first_box_i;
    entry_o.last     = last_box_i;
    entry_o.group    = hit_group_i;
    epsx = {{(DW-8){1'b0}}, eps_i};
    epsn = {{(NW-8){1'b0}}, eps_i};
    for (int f = 0; f < NFACE; f++) begin
      s = coord_of(start_point_i, f >> 1);
      e = coord_of(end_point_i, f >> 1);
      if ((f & 1) != 0) begin
        s     = -s;
        e     = -e;
        pdist = -coord_of(box_min_i, f >> 1);
      end else begin
        pdist = coord_of(box_max_i, f >> 1);
      end
      diff1 = {s[COORD_BITS], s} - {pdist[COORD_BITS], pdist};
      diff2 = {e[COORD_BITS], e} - {pdist[COORD_BITS], pdist};
      // distances in eighths of a unit
      d1    = {diff1, 3'b000};
      d2    = {diff2, 3'b000};
      d1pos = d1 > 0;
      d2pos = d2 > 0;
      d1x   = {d1[DW-1], d1};
      if (d1pos && (d2 >= epsx || d2 >= d1)) entry_o.reject = 1'b1;
      if (d1pos) entry_o.startout = 1'b1;
      if (d2pos) entry_o.getout = 1'b1;
      entry_o.faces[f].active   = d1pos || d2pos;
      entry_o.faces[f].is_enter = d1 > d2;
      if (d1 > d2) begin
        entry_o.faces[f].num = d1x - epsn;
        entry_o.faces[f].den = d1 - d2;
      end else begin
        entry_o.faces[f].num = -(d1x + epsn);
        entry_o.faces[f].den = d2 - d1;
      end
      entry_o.faces[f].plane = sat16(pdist);
    end
  end

endmodule

[rtl/sbct_queue.sv]
// sbct_queue: short queue of classified boxes between front and back
// depends on sbct_pkg
module sbct_queue
  import sbct_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_valid_i,
  output logic   push_ready_o,
  input  entry_t push_data_i,
  output logic   pop_valid_o,
  input  logic   pop_ready_i,
  output entry_t pop_data_o
);

  entry_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wptr_q, rptr_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic                push, pop;

  assign push_ready_o = cnt_q != QCNT_W'(QDEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      if (pop)  rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

[rtl/sbct_back.sv]
// sbct_back: face-by-face sequencer with a serial fraction divider and nearest-hit state
// depends on sbct_pkg, sbct_ifs
module sbct_back
  import sbct_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  entry_t     pop_data_i,
  sbct_out_if.source out_o
);

  back_state_e           state_q;
  entry_t                cur_q;
  logic [2:0]            face_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DW-1:0]         rem_q;
  logic [FRACTION_BITS-1:0] quo_q;
  logic [FW-1:0]         enter_q, leave_q;
  logic                  have_q, skip_q;
  logic [2:0]            eface_q;
  logic signed [15:0]    edist_q;

  logic [FW-1:0]         near_frac_q;
  logic [2:0]            near_face_q;
  logic signed [15:0]    near_dist_q;
  logic [8:0]            group_q;
  logic                  seen_q;

  logic                  out_valid_q, out_hit_q, out_done_q;

  face_t                 fc;
  logic [DW:0]           rem2;
  logic                  qbit;
  logic [DW-1:0]         rem_next;
  logic                  apply_en, advance;
  logic [FW-1:0]         apply_val;
  logic                  num_le0, num_ge_den, can_out;
  logic                  fin_hit, fin_zero, fin_upd;

  assign fc          = cur_q.faces[face_q];
  // a new trace clears the state that the waiting result shows, so hold off until it goes
  assign pop_ready_o = (state_q == S_IDLE) && can_out;
  assign can_out     = !out_valid_q || out_o.ready;
  assign num_le0     = fc.num[NW-1] || (fc.num == '0);
  assign num_ge_den  = fc.num[DW-1:0] >= fc.den;

  // restoring divide step
  assign rem2     = {rem_q, 1'b0};
  assign qbit     = rem2 >= {1'b0, fc.den};
  assign rem_next = qbit ? DW'(rem2 - {1'b0, fc.den}) : rem2[DW-1:0];

  always_comb begin
    apply_en  = 1'b0;
    advance   = 1'b0;
    apply_val = '0;
    case (state_q)
      S_FACE: begin
        if (!fc.active) begin
          advance = 1'b1;
        end else if (num_le0) begin
          apply_en = 1'b1;
          advance  = 1'b1;
        end else if (num_ge_den) begin
          apply_en  = 1'b1;
          advance   = 1'b1;
          apply_val = FRAC_ONE;
        end
      end
      S_DIV: begin
        if (cnt_q == CNT_W'(1)) begin
          apply_en  = 1'b1;
          advance   = 1'b1;
          apply_val = {1'b0, quo_q[FRACTION_BITS-2:0], qbit};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    fin_hit  = 1'b0;
    fin_zero = 1'b0;
    fin_upd  = 1'b0;
    if (!skip_q) begin
      if (!cur_q.startout) begin
        fin_hit  = 1'b1;
        fin_zero = !cur_q.getout;
      end else if (have_q && enter_q < leave_q && enter_q < near_frac_q) begin
        fin_hit = 1'b1;
        fin_upd = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (pop_valid_i) cur_q <= pop_data_i;
      end
      S_FACE: begin
        rem_q <= fc.num[DW-1:0];
        quo_q <= '0;
      end
      S_DIV: begin
        rem_q <= rem_next;
        quo_q <= {quo_q[FRACTION_BITS-2:0], qbit};
      end
      default: ;
    endcase
    if (apply_en && fc.is_enter && (!have_q || apply_val > enter_q)) begin
      eface_q <= face_q;
      edist_q <= fc.plane;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      face_q      <= '0;
      cnt_q       <= '0;
      enter_q     <= '0;
      leave_q     <= FRAC_ONE;
      have_q      <= 1'b0;
      skip_q      <= 1'b0;
      near_frac_q <= FRAC_ONE;
      near_face_q <= FACE_NONE;
      near_dist_q <= '0;
      group_q     <= GROUP_NONE;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
      out_done_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;
      if (apply_en) begin
        if (fc.is_enter) begin
          if (!have_q || apply_val > enter_q) begin
            have_q  <= 1'b1;
            enter_q <= apply_val;
          end
        end else if (apply_val < leave_q) begin
          leave_q <= apply_val;
        end
      end
      if (advance) begin
        face_q  <= face_q + 1'b1;
        state_q <= (face_q == FACE_LAST) ? S_DONE : S_FACE;
      end
      case (state_q)
        S_IDLE: begin
          if (pop_valid_i && can_out) begin
            if (pop_data_i.first) begin
              near_frac_q <= FRAC_ONE;
              near_face_q <= FACE_NONE;
              near_dist_q <= '0;
              group_q     <= GROUP_NONE;
              seen_q      <= 1'b0;
            end
            face_q  <= '0;
            enter_q <= '0;
            leave_q <= FRAC_ONE;
            have_q  <= 1'b0;
            // fraction already zero, or the segment misses a slab outright
            if ((!pop_data_i.first && near_frac_q == '0) || pop_data_i.reject) begin
              skip_q  <= 1'b1;
              state_q <= S_DONE;
            end else begin
              skip_q  <= 1'b0;
              state_q <= S_FACE;
            end
          end
        end
        S_FACE: begin
          if (!advance) begin
            cnt_q   <= CNT_W'(FRACTION_BITS);
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q - 1'b1;
        end
        S_DONE: begin
          if (can_out) begin
            if (fin_zero) near_frac_q <= '0;
            if (fin_upd) begin
              near_frac_q <= enter_q;
              near_face_q <= eface_q;
              near_dist_q <= edist_q;
            end
            if (fin_hit) begin
              group_q <= {1'b0, cur_q.group};
              seen_q  <= 1'b1;
            end
            out_valid_q <= 1'b1;
            out_hit_q   <= fin_hit;
            out_done_q  <= cur_q.last;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // the nearest-hit state is written when the result is loaded, and cleared when a first box is taken
  assign out_o.valid           = out_valid_q;
  assign out_o.box_was_hit     = out_hit_q;
  assign out_o.trace_fraction  = 17'(near_frac_q);
  assign out_o.best_face       = near_face_q;
  assign out_o.best_plane_dist = near_dist_q;
  assign out_o.best_group      = group_q;
  assign out_o.any_hit         = seen_q;
  assign out_o.trace_done      = out_done_q;

endmodule

[rtl/segment_box_clip_trace.sv]
// segment_box_clip_trace: top level, clips a segment against hitboxes, keeps nearest hit
// depends on sbct_pkg, sbct_ifs, sbct_front, sbct_queue, sbct_back
//
//   channel   dir  beat contents
//   in_i      in   start/end points, box corners, hit group, first/last flags
//   out_o     out  hit flag, nearest fraction/face/distance, group, any hit, done
//   cfg       in   cfg_we_i / cfg_wdata_i: clip epsilon, eighths of a unit
//
// one box walks its faces in the back sequencer, and each face whose fraction needs the
// serial divider runs it; the back sequencer with its one divider sets the box rate.
// a rejected box, or one after the fraction reached zero, skips the face walk.
// reset: epsilon 1, no hit, queue empty. a two-beat queue lets input beats land
// while the back end works or the output register waits on out_o.ready.
module segment_box_clip_trace
  import sbct_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  sbct_in_if.sink    in_i,
  sbct_out_if.source out_o
);

  logic [7:0] eps_q;
  entry_t     front_entry, queue_entry;
  logic       queue_valid, back_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) eps_q <= 8'd1;
    else if (cfg_we_i) eps_q <= cfg_wdata_i;
  end

  sbct_front u_front (
    .start_point_i (in_i.start_point),
    .end_point_i   (in_i.end_point),
    .box_min_i     (in_i.box_min),
    .box_max_i     (in_i.box_max),
    .hit_group_i   (in_i.hit_group),
    .first_box_i   (in_i.first_box),
    .last_box_i    (in_i.last_box),
    .eps_i         (eps_q),
    .entry_o       (front_entry)
  );

  sbct_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_i.valid),
    .push_ready_o (in_i.ready),
    .push_data_i  (front_entry),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (queue_entry)
  );

  sbct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (queue_valid),
    .pop_ready_o (back_ready),
    .pop_data_i  (queue_entry),
    .out_o       (out_o)
  );

endmodule

[tb/sv/sbct_clip_sb.sv]
// sbct_clip_sb: scoreboard for the segment/box clip trace block
// predicts the nearest-hit state per box beat; depends on sbct_pkg
`timescale 1ns / 100ps

class sbct_clip_sb;
  typedef struct packed {
    logic               box_was_hit;
    logic [16:0]        trace_fraction;
    logic [2:0]         best_face;
    logic signed [15:0] best_plane_dist;
    logic signed [8:0]  best_group;
    logic               any_hit;
    logic               trace_done;
  } hit_rec_t;

  hit_rec_t          pending_hits[$];
  logic [7:0]        eps;
  longint            near_frac;
  logic [2:0]        near_face;
  logic signed [15:0] near_dist;
  logic signed [8:0] group_seen;
  logic              hit_seen;
  int                mismatches;

  function new();
    eps = 8'd1;
    clear_trace();
    mismatches = 0;
  endfunction

  function void clear_trace();
    near_frac  = longint'(sbct_pkg::FRAC_ONE);
    near_face  = sbct_pkg::FACE_NONE;
    near_dist  = '0;
    group_seen = sbct_pkg::GROUP_NONE;
    hit_seen   = 1'b0;
  endfunction

  function longint coord(logic [47:0] p, int axis);
    logic signed [15:0] c;
    c = p[axis*16 +: 16];
    return longint'(c);
  endfunction

  function longint div_frac(longint num, longint den);
    if (num >= 0) return (num * 65536) / den;
    return -(((-num) * 65536) / den);
  endfunction

  function bit clip_box(logic [47:0] sp, logic [47:0] ep, logic [47:0] bmin,
                        logic [47:0] bmax);
    longint e, enter, leave, s, t, pdist, d1, d2, f, enter_dist;
    bit have_enter, startout, getout, neg;
    logic [2:0] enter_face;
    int axis;
    e = longint'(eps);
    enter = 0;
    leave = 65536;
    have_enter = 0;
    startout = 0;
    getout = 0;
    enter_face = sbct_pkg::FACE_NONE;
    enter_dist = 0;
    for (int face = 0; face < 6; face++) begin
      axis = face >> 1;
      neg = face[0];
      s = coord(sp, axis);
      t = coord(ep, axis);
      pdist = neg ? -coord(bmin, axis) : coord(bmax, axis);
      if (neg) begin
        s = -s;
        t = -t;
      end
      d1 = (s - pdist) * 8;
      d2 = (t - pdist) * 8;
      if (d2 > 0) getout = 1;
      if (d1 > 0) startout = 1;
      if (d1 > 0 && (d2 >= e || d2 >= d1)) return 0;
      if (d1 <= 0 && d2 <= 0) continue;
      if (d1 > d2) begin
        f = d1 - e;
        f = (f <= 0) ? 0 : div_frac(f, d1 - d2);
        if (!have_enter || f > enter) begin
          have_enter = 1;
          enter = f;
          enter_face = face[2:0];
          enter_dist = pdist;
        end
      end else begin
        f = div_frac(-(d1 + e), d2 - d1);
        if (f > 65536) f = 65536;
        if (f < leave) leave = f;
      end
    end
    if (!startout) begin
      if (!getout) near_frac = 0;
      return 1;
    end
    if (have_enter && enter < leave && enter < near_frac) begin
      near_frac = enter;
      near_face = enter_face;
      // plane distance saturates to 16 signed bits
      near_dist = (enter_dist > 32767) ? 16'sd32767 :
                  (enter_dist < -32768) ? -16'sd32768 : 16'(enter_dist);
      return 1;
    end
    return 0;
  endfunction

  function void note_box(logic [47:0] sp, logic [47:0] ep, logic [47:0] bmin,
                         logic [47:0] bmax, logic [7:0] grp, logic first, logic last);
    hit_rec_t r;
    bit hit;
    hit = 0;
    if (first) clear_trace();
    if (near_frac != 0) begin
      hit = clip_box(sp, ep, bmin, bmax);
      if (hit) begin
        group_seen = {1'b0, grp};
        hit_seen = 1'b1;
      end
    end
    r.box_was_hit     = hit;
    r.trace_fraction  = near_frac[16:0];
    r.best_face       = near_face;
    r.best_plane_dist = near_dist;
    r.best_group      = group_seen;
    r.any_hit         = hit_seen;
    r.trace_done      = last;
    pending_hits.push_back(r);
  endfunction

  function void check_result(hit_rec_t got);
    hit_rec_t want;
    if (pending_hits.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat %p", got);
      return;
    end
    want = pending_hits.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
    end
  endfunction
endclass

[tb/sv/segment_box_clip_trace_tb.sv]
// segment_box_clip_trace_tb: random and directed hitbox traces against a predictor
// depends on sbct_pkg, sbct_ifs, sbct_clip_sb and the block's rtl
`timescale 1ns / 100ps

module segment_box_clip_trace_tb;
  import sbct_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  bit         no_idle;
  bit         long_hold;
  bit         inputs_done;

  sbct_in_if  in_i ();
  sbct_out_if out_o ();
  sbct_clip_sb board;

  segment_box_clip_trace u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .out_o       (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  // input beats are noted at the accepting edge
  always @(posedge clk_i) begin
    if (rst_ni && in_i.valid && in_i.ready)
      board.note_box(in_i.start_point, in_i.end_point, in_i.box_min, in_i.box_max,
                     in_i.hit_group, in_i.first_box, in_i.last_box);
    if (rst_ni && out_o.valid && out_o.ready)
      board.check_result('{out_o.box_was_hit, out_o.trace_fraction, out_o.best_face,
                           out_o.best_plane_dist, out_o.best_group, out_o.any_hit,
                           out_o.trace_done});
  end

  // receiver: random stalls in bursts, one long hold-off on request
  initial begin
    int gap;
    out_o.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_o.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold = 0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 19);
        out_o.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        out_o.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  function automatic logic [15:0] rnd_coord(int span);
    int c;
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom);
      default: begin
        c = $urandom_range(0, 2 * span) - span;
        return 16'(c);
      end
    endcase
  endfunction

  // valid stays high after a beat so that back-to-back beats need one assignment
  task automatic send_box(logic [47:0] sp, logic [47:0] ep, logic [47:0] bmin,
                          logic [47:0] bmax, logic [7:0] grp, logic first, logic last);
    int gap;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      in_i.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_i.valid       <= 1'b1;
    in_i.start_point <= sp;
    in_i.end_point   <= ep;
    in_i.box_min     <= bmin;
    in_i.box_max     <= bmax;
    in_i.hit_group   <= grp;
    in_i.first_box   <= first;
    in_i.last_box    <= last;
    do @(posedge clk_i); while (!in_i.ready);
  endtask

  task automatic rand_box(logic first, logic last);
    logic [47:0] sp, ep, bmin, bmax;
    logic [15:0] lo, hi;
    int span;
    span = ($urandom_range(0, 3) == 0) ? 30000 : 64;
    for (int a = 0; a < 3; a++) begin
      sp[a*16 +: 16] = rnd_coord(span);
      ep[a*16 +: 16] = rnd_coord(span);
      lo = rnd_coord(span / 2);
      hi = rnd_coord(span / 2);
      // mostly well-formed boxes, some with min above max
      if ($urandom_range(0, 7) != 0 && $signed(lo) > $signed(hi)) begin
        bmin[a*16 +: 16] = hi;
        bmax[a*16 +: 16] = lo;
      end else begin
        bmin[a*16 +: 16] = lo;
        bmax[a*16 +: 16] = hi;
      end
    end
    send_box(sp, ep, bmin, bmax, 8'($urandom), first, last);
  endtask

  task automatic rand_trace(output int n);
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++)
      rand_box(i == 0 || $urandom_range(0, 30) == 0, i == n - 1);
  endtask

  task automatic wait_drain();
    in_i.valid <= 1'b0;
    while (board.pending_hits.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_eps(logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.eps = v;
  endtask

  initial begin
    logic [47:0] bmin, bmax;
    int cnt;
    int nbox;
    board = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_i.valid = 1'b0;
    in_i.start_point = '0;
    in_i.end_point = '0;
    in_i.box_min = '0;
    in_i.box_max = '0;
    in_i.hit_group = '0;
    in_i.first_box = 1'b0;
    in_i.last_box = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: box -10..10 on all axes
    bmin = {16'hfff6, 16'hfff6, 16'hfff6};
    bmax = {16'd10, 16'd10, 16'd10};
    // entry through each of the six faces
    send_box({16'd0, 16'd0, 16'd50}, 48'd0, bmin, bmax, 8'd1, 1, 0);
    send_box({16'd0, 16'd0, 16'hffce}, 48'd0, bmin, bmax, 8'd2, 1, 1);
    send_box({16'd0, 16'd50, 16'd0}, 48'd0, bmin, bmax, 8'd3, 1, 1);
    send_box({16'd0, 16'hffce, 16'd0}, 48'd0, bmin, bmax, 8'd4, 1, 1);
    send_box({16'd50, 16'd0, 16'd0}, 48'd0, bmin, bmax, 8'd5, 1, 1);
    send_box({16'hffce, 16'd0, 16'd0}, 48'd0, bmin, bmax, 8'hff, 1, 1);
    // start inside, end inside: fraction to zero, then ignored boxes
    send_box(48'd0, {16'd1, 16'd1, 16'd1}, bmin, bmax, 8'd7, 1, 0);
    send_box({16'd0, 16'd0, 16'd50}, 48'd0, bmin, bmax, 8'd8, 0, 1);
    // start inside, end outside
    send_box(48'd0, {16'd0, 16'd0, 16'd50}, bmin, bmax, 8'd9, 1, 0);
    // wholly in front of a face: rejected; no first_box carries state over
    send_box({16'd0, 16'd0, 16'd50}, {16'd0, 16'd0, 16'd60}, bmin, bmax, 8'd10, 0, 1);
    // diagonal tie between faces
    send_box({16'd50, 16'd50, 16'd50}, 48'd0, bmin, bmax, 8'd11, 1, 1);
    // extreme coordinates, saturating plane distance
    send_box({3{16'h7fff}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h7fff}}, 8'd12, 1, 1);
    send_box({3{16'h8000}}, {3{16'h7fff}}, {3{16'h8000}}, {3{16'h0000}}, 8'd13, 1, 1);
    send_box({3{16'hffff}}, {3{16'hffff}}, {3{16'hffff}}, {3{16'hffff}}, 8'd0, 1, 1);
    send_box({3{16'h5555}}, {3{16'haaaa}}, {3{16'haaaa}}, {3{16'h5555}}, 8'h55, 1, 1);
    wait_drain();

    cnt = 0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_eps(8'd0);
        1: write_eps(8'd255);
        2: write_eps(8'd1);
        default: write_eps(8'($urandom));
      endcase
      if (phase == 2) long_hold = 1;
      if (phase == 5) no_idle = 1;
      while (cnt < (phase + 1) * 280) begin
        rand_trace(nbox);
        cnt += nbox;
      end
      // sender pauses until every expected result is in
      wait_drain();
    end

    if (board.mismatches == 0 && board.pending_hits.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule

[sim.f]
rtl/sbct_pkg.sv
rtl/sbct_ifs.sv
rtl/sbct_front.sv
rtl/sbct_queue.sv
rtl/sbct_back.sv
rtl/segment_box_clip_trace.sv
tb/sv/sbct_clip_sb.sv
tb/sv/segment_box_clip_trace_tb.sv
